>>> sv/ulw_pkg.sv
// ----------------------------------------------------------------------------
// ulw_pkg
// Shared types and constants for the UTF-8 greedy line wrapper.
// ----------------------------------------------------------------------------
package ulw_pkg;

  localparam int OFF_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CNT_W      = 7;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

  localparam logic [7:0]  NEWLINE   = 8'h0A;
  localparam logic [20:0] ASCII_MAX = 21'h00007F;

  localparam logic [7:0] RST_LINE_WIDTH = 8'd128;
  localparam logic [4:0] RST_NARROW_PX  = 5'd8;
  localparam logic [5:0] RST_WIDE_PX    = 6'd16;
  localparam logic [6:0] RST_MAX_LINES  = 7'd64;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_NARROW_PX  = 2'd1,
    REG_WIDE_PX    = 2'd2,
    REG_MAX_LINES  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] line_width_px;
    logic [4:0] narrow_char_px;
    logic [5:0] wide_char_px;
    logic [6:0] max_lines;
  } cfg_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             line_valid;
    logic             end_of_text;
    logic [CNT_W-1:0] line_count;
  } result_t;

endpackage

>>> sv/ulw_step.sv
// ----------------------------------------------------------------------------
// ulw_step
// Per-byte decode, width accounting and line break decision; holds the text
// state and produces up to two line results for each byte.
// ----------------------------------------------------------------------------
module ulw_step #(
  parameter int TEXT_MAX  = 1024,
  parameter int LINES_MAX = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  ulw_pkg::cfg_t    cfg,
  input  logic             advance,
  input  logic [7:0]       text_byte,
  input  logic             last_byte,
  output logic [1:0]       push_count,
  output ulw_pkg::result_t push0,
  output ulw_pkg::result_t push1
);
  import ulw_pkg::*;

  localparam int POS_W   = $clog2(TEXT_MAX + 1);
  localparam int LEAD_W  = $clog2(TEXT_MAX);
  localparam int LIM_CAP = (LINES_MAX > 127) ? 127 : LINES_MAX;

  logic [POS_W-1:0]  bpos, bpos_next;
  logic [POS_W-1:0]  lstart, lstart_next;
  logic [8:0]        used, used_next;
  logic [1:0]        pend, pend_next;
  logic [20:0]       cp, cp_next;
  logic [LEAD_W-1:0] lead, lead_next;
  logic [CNT_W-1:0]  lines, lines_next;

  logic [CNT_W-1:0]  lim;
  logic              in_range;
  logic [20:0]       cp_a;
  logic [1:0]        pend_a;
  logic [LEAD_W-1:0] lead_a;
  logic [POS_W-1:0]  bpos_a;
  logic [POS_W-1:0]  lead_pos;
  logic              fin;
  logic              nl;
  logic              fin_all;
  logic [5:0]        w;
  logic [9:0]        sum;
  logic              brk;
  logic              e1_emit;
  logic [POS_W-1:0]  e1_len;
  logic [CNT_W-1:0]  lines_b;
  logic [POS_W-1:0]  lstart_b;
  logic [8:0]        used_b;
  logic              e2_emit;
  result_t           r_e1;
  result_t           r_fin;

  assign lim = (cfg.max_lines < CNT_W'(LIM_CAP)) ? cfg.max_lines : CNT_W'(LIM_CAP);

  always_comb begin
    in_range = bpos < POS_W'(TEXT_MAX);
    cp_a     = cp;
    pend_a   = pend;
    lead_a   = lead;
    fin      = 1'b0;
    nl       = 1'b0;
    bpos_a   = bpos;
    if (in_range) begin
      bpos_a = bpos + POS_W'(1);
      if (pend != 2'd0) begin
        cp_a   = {cp[14:0], text_byte[5:0]};
        pend_a = pend - 2'd1;
        fin    = (pend_a == 2'd0);
      end else begin
        case (text_byte) inside
          8'b0???????: begin
            if (text_byte == NEWLINE) begin
              nl = 1'b1;
            end else begin
              lead_a = LEAD_W'(bpos);
              cp_a   = {13'd0, text_byte};
              fin    = 1'b1;
            end
          end
          8'b110?????: begin
            lead_a = LEAD_W'(bpos);
            cp_a   = {16'd0, text_byte[4:0]};
            pend_a = 2'd1;
          end
          8'b1110????: begin
            lead_a = LEAD_W'(bpos);
            cp_a   = {17'd0, text_byte[3:0]};
            pend_a = 2'd2;
          end
          8'b11110???: begin
            lead_a = LEAD_W'(bpos);
            cp_a   = {18'd0, text_byte[2:0]};
            pend_a = 2'd3;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    lead_pos = POS_W'(lead_a);
    fin_all  = fin || (last_byte && pend_a != 2'd0);
    w        = (cp_a <= ASCII_MAX) ? {1'b0, cfg.narrow_char_px} : cfg.wide_char_px;
    sum      = {1'b0, used} + 10'(w);
    brk      = fin_all && (sum > 10'(cfg.line_width_px)) && (used != 9'd0);
    e1_len   = brk ? (lead_pos - lstart) : (bpos - lstart);
    e1_emit  = (brk || nl) && (lines < lim);
    lines_b  = lines + CNT_W'(e1_emit);
    if (brk) begin
      lstart_b = lead_pos;
      used_b   = 9'(w);
    end else if (nl) begin
      lstart_b = bpos + POS_W'(1);
      used_b   = 9'd0;
    end else begin
      lstart_b = lstart;
      used_b   = fin_all ? sum[8:0] : used;
    end
    e2_emit = (bpos_a > lstart_b) && (lines_b < lim);

    r_e1.offset      = OFF_W'(lstart);
    r_e1.length      = LEN_W'(e1_len);
    r_e1.line_valid  = 1'b1;
    r_e1.end_of_text = 1'b0;
    r_e1.line_count  = lines_b;

    if (e2_emit) begin
      r_fin.offset      = OFF_W'(lstart_b);
      r_fin.length      = LEN_W'(bpos_a - lstart_b);
      r_fin.line_valid  = 1'b1;
      r_fin.end_of_text = 1'b1;
      r_fin.line_count  = lines_b + CNT_W'(1);
    end else begin
      r_fin.offset      = '0;
      r_fin.length      = '0;
      r_fin.line_valid  = 1'b0;
      r_fin.end_of_text = 1'b1;
      r_fin.line_count  = lines_b;
    end
  end

  always_comb begin
    push_count = 2'd0;
    push0      = r_e1;
    push1      = r_fin;
    if (advance) begin
      push_count = {1'b0, e1_emit} + {1'b0, last_byte};
      if (!e1_emit) begin
        push0 = r_fin;
      end
    end
  end

  always_comb begin
    bpos_next   = bpos;
    lstart_next = lstart;
    used_next   = used;
    pend_next   = pend;
    cp_next     = cp;
    lead_next   = lead;
    lines_next  = lines;
    if (advance) begin
      if (last_byte) begin
        bpos_next   = '0;
        lstart_next = '0;
        used_next   = '0;
        pend_next   = '0;
        cp_next     = '0;
        lead_next   = '0;
        lines_next  = '0;
      end else begin
        bpos_next   = bpos_a;
        lstart_next = lstart_b;
        used_next   = used_b;
        pend_next   = pend_a;
        cp_next     = cp_a;
        lead_next   = lead_a;
        lines_next  = lines_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpos   <= '0;
      lstart <= '0;
      used   <= '0;
      pend   <= '0;
      cp     <= '0;
      lead   <= '0;
      lines  <= '0;
    end else begin
      bpos   <= bpos_next;
      lstart <= lstart_next;
      used   <= used_next;
      pend   <= pend_next;
      cp     <= cp_next;
      lead   <= lead_next;
      lines  <= lines_next;
    end
  end

endmodule

>>> sv/ulw_outq.sv
// ----------------------------------------------------------------------------
// ulw_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module ulw_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  ulw_pkg::result_t push0,
  input  ulw_pkg::result_t push1,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output ulw_pkg::result_t head
);
  import ulw_pkg::*;

  result_t               entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [OUTQ_PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [OUTQ_PTR_W:0]   count, count_next;
  logic                  pop;

  assign out_valid = (count != '0);
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign space     = (count <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH - 2));

  always_comb begin
    rd_ptr_next = rd_ptr + OUTQ_PTR_W'(pop);
    wr_ptr_next = wr_ptr + OUTQ_PTR_W'(push_count);
    count_next  = count + (OUTQ_PTR_W+1)'(push_count) - (OUTQ_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + OUTQ_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

endmodule

>>> sv/utf8_greedy_line_wrapper_top.sv
// ----------------------------------------------------------------------------
// utf8_greedy_line_wrapper_top
// Greedy line wrapping of a UTF-8 byte stream into line offset/length words.
//
// Input channel (in_valid/in_ready) carries one text byte per word, with
// last_byte marking the end of a text. Output channel (out_valid/out_ready)
// carries line words: offset, length, line_valid, end_of_text, line_count.
// Each byte yields zero, one or two output words; the last byte of a text
// always yields a closing word with end_of_text set.
// An accepted byte lands in an input register; once the queue has space, it
// is decoded and its results are written into a four-entry output queue,
// whose head drives the output. One byte per cycle is sustained while the
// queue has space; the decode and width compare stage takes the held byte
// in the same cycle as the next byte is accepted.
// When the receiver stalls, the queue fills and in_ready drops while a byte
// waits in the input register with fewer than two entries free; no word is
// lost.
// Reset clears the text state and the queue and loads the register defaults
// (width 128, narrow 8, wide 16, max lines 64). Register writes through
// cfg_write/cfg_index/cfg_data are registered.
// ----------------------------------------------------------------------------
module utf8_greedy_line_wrapper_top #(
  parameter int TEXT_MAX  = 1024,
  parameter int LINES_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  line_offset,
  output logic [10:0] line_length,
  output logic        line_valid,
  output logic        end_of_text,
  output logic [6:0]  line_count
);
  import ulw_pkg::*;

  cfg_t       cfg;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       space;
  logic       advance;
  logic [1:0] push_count;
  result_t    push0;
  result_t    push1;
  result_t    head;

  assign advance  = in_full && space;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width_px  <= RST_LINE_WIDTH;
      cfg.narrow_char_px <= RST_NARROW_PX;
      cfg.wide_char_px   <= RST_WIDE_PX;
      cfg.max_lines      <= RST_MAX_LINES;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_LINE_WIDTH: cfg.line_width_px  <= cfg_data;
        REG_NARROW_PX:  cfg.narrow_char_px <= cfg_data[4:0];
        REG_WIDE_PX:    cfg.wide_char_px   <= cfg_data[5:0];
        REG_MAX_LINES:  cfg.max_lines      <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= text_byte;
      in_last <= last_byte;
    end
  end

  ulw_step #(
    .TEXT_MAX  (TEXT_MAX),
    .LINES_MAX (LINES_MAX)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .advance    (advance),
    .text_byte  (in_byte),
    .last_byte  (in_last),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1)
  );

  ulw_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .space      (space),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign line_offset = head.offset;
  assign line_length = head.length;
  assign line_valid  = head.line_valid;
  assign end_of_text = head.end_of_text;
  assign line_count  = head.line_count;

endmodule
